@@ hw/rtl/tmgd_pkg.sv @@
// ----------------------------------------------------------------------------
// tmgd_pkg: shared types and constants for the trilinear mass grid deposit
// Command format between front and back end, codes and fixed field widths.
// ----------------------------------------------------------------------------
package tmgd_pkg;

  localparam int CELL_W      = 8;
  localparam int FRAC_W      = 16;
  localparam int MASS_W      = 16;
  localparam int VOX_W       = 32;
  localparam int WEIGHT_W    = 17;
  localparam int ADD_W       = 25;
  localparam int G_W         = 58;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;
  localparam int IN_DATA_W   = 128;
  localparam int IN_USER_W   = 3;
  localparam int OUT_DATA_W  = 32;
  localparam int OUT_USER_W  = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [1:0] {
    OP_DEPOSIT = 2'd0,
    OP_READ    = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HETERO  = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_SAT     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_DEPOSIT,
    KIND_READ,
    KIND_CLEAR,
    KIND_RESULT
  } cmd_kind_t;

  typedef enum logic [2:0] {
    REG_INV_SPACING = 3'd0,
    REG_ORIGIN_X    = 3'd1,
    REG_ORIGIN_Y    = 3'd2,
    REG_ORIGIN_Z    = 3'd3,
    REG_USE_HETATM  = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_ISSUE,
    BK_DRAIN
  } back_state_t;

  typedef struct packed {
    logic [23:0] inv_spacing;
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] origin_z;
    logic        use_hetatm;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t         kind;
    status_t           status;
    logic [CELL_W-1:0] cx;
    logic [CELL_W-1:0] cy;
    logic [CELL_W-1:0] cz;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
    logic [FRAC_W-1:0] fz;
    logic [MASS_W-1:0] mass;
  } cmd_t;

endpackage

@@ hw/rtl/tmgd_front.sv @@
// ----------------------------------------------------------------------------
// tmgd_front: transaction intake and classification
// Maps atom positions to grid units, checks hetero and range rules, and
// pushes one command per transaction into the command queue.
// ----------------------------------------------------------------------------
module tmgd_front
  import tmgd_pkg::*;
#(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 clearing,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [IN_USER_W-1:0] in_tuser,
  output logic                 q_push,
  output cmd_t                 q_cmd,
  input  logic                 q_ready
);

  localparam logic [G_W-33:0] GX_MAX = (G_W-32)'(GRID_X - 2);
  localparam logic [G_W-33:0] GY_MAX = (G_W-32)'(GRID_Y - 2);
  localparam logic [G_W-33:0] GZ_MAX = (G_W-32)'(GRID_Z - 2);
  localparam logic signed [G_W-1:0] MARGIN_G = G_W'(2) << 32;

  logic en;

  logic              f1_valid_r;
  opcode_t           f1_op_r;
  logic              f1_het_r;
  logic [MASS_W-1:0] f1_mass_r;
  logic signed [32:0] f1_dx_r, f1_dy_r, f1_dz_r;
  logic [4:0]        f1_cx_r, f1_cy_r, f1_cz_r;

  logic              f2_valid_r;
  opcode_t           f2_op_r;
  logic              f2_het_r;
  logic [MASS_W-1:0] f2_mass_r;
  logic signed [G_W-1:0] f2_gx_r, f2_gy_r, f2_gz_r;
  logic [4:0]        f2_cx_r, f2_cy_r, f2_cz_r;

  logic signed [G_W-1:0] gx_nxt, gy_nxt, gz_nxt;
  logic signed [32:0] dx_nxt, dy_nxt, dz_nxt;
  logic signed [24:0] inv_s;
  logic out_x, out_y, out_z, cell_bad;

  assign en        = !f2_valid_r || q_ready;
  assign in_tready = en && !clearing;
  assign q_push    = f2_valid_r;

  assign dx_nxt = $signed({in_tdata[31], in_tdata[31:0]}) -
                  $signed({cfg.origin_x[31], cfg.origin_x});
  assign dy_nxt = $signed({in_tdata[63], in_tdata[63:32]}) -
                  $signed({cfg.origin_y[31], cfg.origin_y});
  assign dz_nxt = $signed({in_tdata[95], in_tdata[95:64]}) -
                  $signed({cfg.origin_z[31], cfg.origin_z});

  assign inv_s  = $signed({1'b0, cfg.inv_spacing});
  assign gx_nxt = f1_dx_r * inv_s + MARGIN_G;
  assign gy_nxt = f1_dy_r * inv_s + MARGIN_G;
  assign gz_nxt = f1_dz_r * inv_s + MARGIN_G;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else if (en) begin
      f1_valid_r <= in_tvalid && in_tready;
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_op_r   <= opcode_t'(in_tuser[1:0]);
      f1_het_r  <= in_tuser[2];
      f1_mass_r <= in_tdata[111:96];
      f1_dx_r   <= dx_nxt;
      f1_dy_r   <= dy_nxt;
      f1_dz_r   <= dz_nxt;
      f1_cx_r   <= in_tdata[116:112];
      f1_cy_r   <= in_tdata[121:117];
      f1_cz_r   <= in_tdata[126:122];
      f2_op_r   <= f1_op_r;
      f2_het_r  <= f1_het_r;
      f2_mass_r <= f1_mass_r;
      f2_gx_r   <= gx_nxt;
      f2_gy_r   <= gy_nxt;
      f2_gz_r   <= gz_nxt;
      f2_cx_r   <= f1_cx_r;
      f2_cy_r   <= f1_cy_r;
      f2_cz_r   <= f1_cz_r;
    end
  end

  // upper neighbour must stay inside the grid
  assign out_x = f2_gx_r[G_W-1] || (f2_gx_r[G_W-1:32] > GX_MAX);
  assign out_y = f2_gy_r[G_W-1] || (f2_gy_r[G_W-1:32] > GY_MAX);
  assign out_z = f2_gz_r[G_W-1] || (f2_gz_r[G_W-1:32] > GZ_MAX);
  assign cell_bad = (9'(f2_cx_r) >= 9'(GRID_X)) || (9'(f2_cy_r) >= 9'(GRID_Y)) ||
                    (9'(f2_cz_r) >= 9'(GRID_Z));

  always_comb begin
    q_cmd        = '0;
    q_cmd.kind   = KIND_RESULT;
    q_cmd.status = ST_OK;
    q_cmd.mass   = f2_mass_r;
    case (f2_op_r)
      OP_DEPOSIT: begin
        q_cmd.cx = f2_gx_r[32 +: CELL_W];
        q_cmd.cy = f2_gy_r[32 +: CELL_W];
        q_cmd.cz = f2_gz_r[32 +: CELL_W];
        q_cmd.fx = f2_gx_r[31:16];
        q_cmd.fy = f2_gy_r[31:16];
        q_cmd.fz = f2_gz_r[31:16];
        if (f2_het_r && !cfg.use_hetatm) begin
          q_cmd.status = ST_HETERO;
        end else if (out_x || out_y || out_z) begin
          q_cmd.status = ST_OUTSIDE;
        end else begin
          q_cmd.kind = KIND_DEPOSIT;
        end
      end
      OP_READ, OP_CLEAR: begin
        q_cmd.cx = CELL_W'(f2_cx_r);
        q_cmd.cy = CELL_W'(f2_cy_r);
        q_cmd.cz = CELL_W'(f2_cz_r);
        if (cell_bad) begin
          q_cmd.status = ST_OUTSIDE;
        end else begin
          q_cmd.kind = (f2_op_r == OP_READ) ? KIND_READ : KIND_CLEAR;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/tmgd_queue.sv @@
// ----------------------------------------------------------------------------
// tmgd_queue: command queue between front and back end
// Small register FIFO so that intake and grid updates stall independently.
// ----------------------------------------------------------------------------
module tmgd_queue
  import tmgd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_cmd
);

  cmd_t              entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              push_fire, pop_fire;

  assign push_ready = count_r != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_cmd    = entries_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_fire) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop_fire) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push_fire && !pop_fire) begin
        count_r <= count_r + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) entries_r[wr_ptr_r] <= push_cmd;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("command queue count beyond depth");
`endif

endmodule

@@ hw/rtl/tmgd_back.sv @@
// ----------------------------------------------------------------------------
// tmgd_back: grid update engine
// Runs commands against the voxel memory: eight pipelined read-modify-write
// corner updates per deposit, single accesses for read and clear.
// ----------------------------------------------------------------------------
module tmgd_back
  import tmgd_pkg::*;
#(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  q_cmd,
  input  logic                  q_valid,
  output logic                  q_pop,
  output logic                  clearing,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser
);

  localparam int DEPTH  = GRID_X * GRID_Y * GRID_Z;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0]   LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [WEIGHT_W-1:0] W_ONE     = WEIGHT_W'(65536);

  logic [VOX_W-1:0] grid_mem [DEPTH];

  back_state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  cmd_t              cmd_r;
  logic [2:0]        slot_r, slot_nxt;
  logic              sat_r;
  logic              issue, slot_last;

  logic [WEIGHT_W-1:0] wx, wy, wz;
  logic [2*WEIGHT_W-1:0] prod_xy, prod_w;
  logic [MASS_W+WEIGHT_W-1:0] prod_m;
  logic [31:0]       lin;
  logic [ADDR_W-1:0] addr_nxt;

  logic                p1_valid_r, p1_last_r;
  logic [ADDR_W-1:0]   p1_addr_r;
  logic [WEIGHT_W-1:0] p1_wxy_r, p1_wz_r;
  logic                p2_valid_r, p2_last_r;
  logic [ADDR_W-1:0]   p2_addr_r;
  logic [WEIGHT_W-1:0] p2_w_r;
  logic                p3_valid_r, p3_last_r;
  logic [ADDR_W-1:0]   p3_addr_r;
  logic [ADD_W-1:0]    p3_add_r;
  logic [VOX_W-1:0]    rd_data_r;

  logic [VOX_W:0]    sum;
  logic              sat_now;
  logic [VOX_W-1:0]  upd_val;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [VOX_W-1:0]  mem_wdata;

  logic             out_valid_r;
  logic [VOX_W-1:0] out_value_r;
  status_t          out_status_r;
  logic             finish;

  assign clearing   = (state_r == BK_CLEAR);
  assign slot_last  = (cmd_r.kind != KIND_DEPOSIT) || (slot_r == 3'd7);
  assign finish     = p3_valid_r && p3_last_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    q_pop     = 1'b0;
    issue     = 1'b0;
    case (state_r)
      BK_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (q_valid && (!out_valid_r || out_tready)) begin
          q_pop     = 1'b1;
          slot_nxt  = '0;
          state_nxt = BK_ISSUE;
        end
      end
      BK_ISSUE: begin
        issue    = 1'b1;
        slot_nxt = slot_r + 1'b1;
        if (slot_last) state_nxt = BK_DRAIN;
      end
      BK_DRAIN: begin
        if (finish) state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // corner weights; slot bits select x, y and z neighbours
  assign wx = slot_r[2] ? WEIGHT_W'(cmd_r.fx) : W_ONE - WEIGHT_W'(cmd_r.fx);
  assign wy = slot_r[1] ? WEIGHT_W'(cmd_r.fy) : W_ONE - WEIGHT_W'(cmd_r.fy);
  assign wz = slot_r[0] ? WEIGHT_W'(cmd_r.fz) : W_ONE - WEIGHT_W'(cmd_r.fz);
  assign prod_xy = wx * wy;
  assign prod_w  = p1_wxy_r * p1_wz_r;
  assign prod_m  = cmd_r.mass * p2_w_r;

  assign lin = (((32'(cmd_r.cz) + 32'(slot_r[0])) * 32'(GRID_Y) +
                 (32'(cmd_r.cy) + 32'(slot_r[1]))) * 32'(GRID_X)) +
               (32'(cmd_r.cx) + 32'(slot_r[2]));
  assign addr_nxt = lin[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      slot_r     <= '0;
      sat_r      <= 1'b0;
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing) clr_addr_r <= clr_addr_r + 1'b1;
      slot_r     <= slot_nxt;
      p1_valid_r <= issue;
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r;
      if (q_pop) begin
        sat_r <= 1'b0;
      end else if (p3_valid_r && cmd_r.kind == KIND_DEPOSIT && sat_now) begin
        sat_r <= 1'b1;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_cmd;
    p1_last_r <= issue && slot_last;
    p1_addr_r <= addr_nxt;
    p1_wxy_r  <= prod_xy[32:16];
    p1_wz_r   <= wz;
    p2_last_r <= p1_last_r;
    p2_addr_r <= p1_addr_r;
    p2_w_r    <= prod_w[32:16];
    p3_last_r <= p2_last_r;
    p3_addr_r <= p2_addr_r;
    p3_add_r  <= prod_m[MASS_W+WEIGHT_W-1:8];
  end

  assign sum     = {1'b0, rd_data_r} + (VOX_W+1)'(p3_add_r);
  assign sat_now = sum[VOX_W];
  assign upd_val = sat_now ? '1 : sum[VOX_W-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = p3_addr_r;
    mem_wdata = upd_val;
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (p3_valid_r && cmd_r.kind == KIND_DEPOSIT) begin
      mem_we = 1'b1;
    end else if (p3_valid_r && cmd_r.kind == KIND_CLEAR) begin
      mem_we    = 1'b1;
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= grid_mem[p2_addr_r];
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      case (cmd_r.kind)
        KIND_DEPOSIT: begin
          out_value_r  <= '0;
          out_status_r <= (sat_r || sat_now) ? ST_SAT : ST_OK;
        end
        KIND_READ, KIND_CLEAR: begin
          out_value_r  <= rd_data_r;
          out_status_r <= cmd_r.status;
        end
        default: begin
          out_value_r  <= '0;
          out_status_r <= cmd_r.status;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid_r)
    else $error("result presented during clearing pass");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == BK_IDLE) && q_valid)
    else $error("command taken outside idle");

  a_pipe_in_command: assert property (@(posedge clk) disable iff (!rst_n)
    p3_valid_r |-> (state_r == BK_ISSUE || state_r == BK_DRAIN))
    else $error("update stage busy with no command in flight");

  a_finish_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r)
    else $error("finished command produced no result");
`endif

endmodule

@@ hw/rtl/trilinear_mass_grid_deposit.sv @@
// ----------------------------------------------------------------------------
// trilinear_mass_grid_deposit: cloud-in-cell mass deposition into a 3D grid
// Register file, command front end, queue and grid update engine.
//
//   port group  role     tdata                      tuser
//   in_*        slave    pos_x,pos_y,pos_z,mass,    opcode, is_hetero
//                        cell_x,cell_y,cell_z
//   out_*       master   voxel_value                status
//   cfg_*       APB      inv_spacing, origin_x/y/z, use_hetatm at 4*i
//
// Front end: the f1 and f2 registers (position multiply) lead to the queue.
// Back end: a deposit runs eight corner slots through the p1/p2/p3 weight and
// read-modify-write pipeline, a read, clear or rejected one a single slot;
// it takes a new command only once the last has ended. A reset clearing pass
// zeroes all GRID_X*GRID_Y*GRID_Z voxels, with in_tready low. A held output
// stalls the back end; intake stops once the four-entry queue and f2 are full.
// ----------------------------------------------------------------------------
module trilinear_mass_grid_deposit
  import tmgd_pkg::*;
#(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pos_x[31:0] pos_y[63:32] pos_z[95:64] mass[111:96]
  // cell_x[116:112] cell_y[121:117] cell_z[126:122], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode[1:0] is_hetero[2]
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // voxel_value[31:0]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [OUT_USER_W-1:0] out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t       cfg_r;
  reg_index_t reg_idx;
  logic       cfg_wr;
  logic       clearing;
  logic       q_push, q_ready, q_pop, q_valid;
  cmd_t       push_cmd, pop_cmd;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_index_t'(cfg_paddr[CFG_AW-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_spacing <= 24'd65536;
      cfg_r.origin_x    <= '0;
      cfg_r.origin_y    <= '0;
      cfg_r.origin_z    <= '0;
      cfg_r.use_hetatm  <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_INV_SPACING: cfg_r.inv_spacing <= cfg_pwdata[23:0];
        REG_ORIGIN_X:    cfg_r.origin_x    <= cfg_pwdata;
        REG_ORIGIN_Y:    cfg_r.origin_y    <= cfg_pwdata;
        REG_ORIGIN_Z:    cfg_r.origin_z    <= cfg_pwdata;
        REG_USE_HETATM:  cfg_r.use_hetatm  <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INV_SPACING: cfg_prdata = CFG_DW'(cfg_r.inv_spacing);
      REG_ORIGIN_X:    cfg_prdata = cfg_r.origin_x;
      REG_ORIGIN_Y:    cfg_prdata = cfg_r.origin_y;
      REG_ORIGIN_Z:    cfg_prdata = cfg_r.origin_z;
      REG_USE_HETATM:  cfg_prdata = CFG_DW'(cfg_r.use_hetatm);
      default:         cfg_prdata = '0;
    endcase
  end

  tmgd_front #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .clearing  (clearing),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .q_ready   (q_ready)
  );

  tmgd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_cmd    (pop_cmd)
  );

  tmgd_back #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_cmd      (pop_cmd),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
